[rtl/slsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slsa_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH-2:0]        step_t;

  localparam value_t RST_SETPOINT     = VALUE_WIDTH'(6553600);
  localparam value_t RST_LIMIT_LOW    = VALUE_WIDTH'(0);
  localparam value_t RST_LIMIT_HIGH   = VALUE_WIDTH'(16384000);
  localparam step_t  RST_MAX_STEP     = (VALUE_WIDTH-1)'(655360);
  localparam value_t RST_LOW_ALARM    = VALUE_WIDTH'(1310720);
  localparam value_t RST_LOW_WARNING  = VALUE_WIDTH'(3276800);
  localparam value_t RST_HIGH_ALARM   = VALUE_WIDTH'(15073280);
  localparam value_t RST_HIGH_WARNING = VALUE_WIDTH'(13107200);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LIMIT_LOW    = 3'd0,
    REG_LIMIT_HIGH   = 3'd1,
    REG_MAX_STEP     = 3'd2,
    REG_LOW_ALARM    = 3'd3,
    REG_LOW_WARNING  = 3'd4,
    REG_HIGH_ALARM   = 3'd5,
    REG_HIGH_WARNING = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEV_NONE  = 2'd0,
    SEV_MINOR = 2'd1,
    SEV_MAJOR = 2'd2
  } sev_t;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_MINOR_LOW  = 3'd1,
    KIND_MINOR_HIGH = 3'd2,
    KIND_MAJOR_LOW  = 3'd3,
    KIND_MAJOR_HIGH = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_FULL       = 2'd0,
    ST_LIMITS_BAD = 2'd1,
    ST_AT_TARGET  = 2'd2,
    ST_ALARM_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    value_t limit_low;
    value_t limit_high;
    step_t  max_step;
    value_t low_alarm;
    value_t low_warning;
    value_t high_alarm;
    value_t high_warning;
  } cfg_t;

  typedef struct packed {
    logic  ok;
    sev_t  sev;
    kind_t kind;
  } alarm_t;

endpackage

`default_nettype wire

[rtl/slsa_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface slsa_in_if import slsa_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t presented_value;

  modport source (output valid, output presented_value, input ready);
  modport sink (input valid, input presented_value, output ready);
endinterface

interface slsa_out_if import slsa_pkg::*; ();
  logic       valid;
  logic       ready;
  value_t     value_out;
  logic [1:0] severity;
  logic [2:0] alarm_kind;
  logic [1:0] pass_status;

  modport source (output valid, output value_out, output severity, output alarm_kind,
                  output pass_status, input ready);
  modport sink (input valid, input value_out, input severity, input alarm_kind,
                input pass_status, output ready);
endinterface

interface slsa_cfg_if import slsa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [VALUE_WIDTH-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/slsa_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module slsa_cfg import slsa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  slsa_cfg_if.sink  cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.limit_low    <= RST_LIMIT_LOW;
      regs.limit_high   <= RST_LIMIT_HIGH;
      regs.max_step     <= RST_MAX_STEP;
      regs.low_alarm    <= RST_LOW_ALARM;
      regs.low_warning  <= RST_LOW_WARNING;
      regs.high_alarm   <= RST_HIGH_ALARM;
      regs.high_warning <= RST_HIGH_WARNING;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LIMIT_LOW:    regs.limit_low    <= cfg.data;
        REG_LIMIT_HIGH:   regs.limit_high   <= cfg.data;
        REG_MAX_STEP:     regs.max_step     <= cfg.data[VALUE_WIDTH-2:0];
        REG_LOW_ALARM:    regs.low_alarm    <= cfg.data;
        REG_LOW_WARNING:  regs.low_warning  <= cfg.data;
        REG_HIGH_ALARM:   regs.high_alarm   <= cfg.data;
        REG_HIGH_WARNING: regs.high_warning <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/slsa_alarm.sv]
`timescale 1ns / 1ps
`default_nettype none

module slsa_alarm import slsa_pkg::*; (
  input  wire value_t value,
  input  wire cfg_t   regs,
  output alarm_t      alarm
);

  always_comb begin
    alarm.ok = (regs.low_alarm < regs.low_warning) &&
               (regs.high_alarm > regs.high_warning) &&
               (regs.low_warning < regs.high_warning);
    if (value <= regs.low_alarm) begin
      alarm.sev  = SEV_MAJOR;
      alarm.kind = KIND_MAJOR_LOW;
    end else if (value <= regs.low_warning) begin
      alarm.sev  = SEV_MINOR;
      alarm.kind = KIND_MINOR_LOW;
    end else if (value >= regs.high_alarm) begin
      alarm.sev  = SEV_MAJOR;
      alarm.kind = KIND_MAJOR_HIGH;
    end else if (value >= regs.high_warning) begin
      alarm.sev  = SEV_MINOR;
      alarm.kind = KIND_MINOR_HIGH;
    end else begin
      alarm.sev  = SEV_NONE;
      alarm.kind = KIND_NONE;
    end
  end

endmodule

`default_nettype wire

[rtl/slew_limited_setpoint_with_alarms.sv]
`timescale 1ns / 1ps
`default_nettype none

// Slew-limited setpoint with alarm thresholds, signed Q16.16. Each word on
// the item channel is one processing pass and yields exactly one word on the
// result channel, in order. The block takes a new word every cycle while the
// result is not stalled: a word is held in the input register, the clamp,
// step and alarm logic run on it against the kept target, current value and
// severity, and the result lands in the output register. The sustained rate
// is one word per cycle, set by the registered target and current state update
// loop. A stalled result only holds off the input once the input register is
// also full. Configuration writes are always taken and must be made while no
// word is in flight; an index beyond the register list is ignored.
module slew_limited_setpoint_with_alarms import slsa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  slsa_in_if.sink    item,
  slsa_out_if.source result,
  slsa_cfg_if.sink   cfg
);

  cfg_t   regs;
  alarm_t alarm;

  logic   valid_a;
  value_t pv_a;
  logic   move_a;

  value_t  target;
  value_t  current;
  sev_t    kept_sev;
  kind_t   kept_kind;

  value_t  target_next;
  value_t  current_next;
  sev_t    sev_next;
  kind_t   kind_next;
  value_t  vout_next;
  status_t status_next;

  logic                   valid_b;
  value_t                 vout;
  sev_t                   sev_out;
  kind_t                  kind_out;
  status_t                status_out;

  logic                   limits_ok;
  logic                   fresh;
  value_t                 pv_lo;
  value_t                 pv_clamp;
  value_t                 tgt_sel;
  logic signed [VALUE_WIDTH:0] diff;
  logic signed [VALUE_WIDTH:0] diff_neg;
  logic                   up;
  logic [VALUE_WIDTH-1:0] gap;
  logic [VALUE_WIDTH-1:0] step_ext;
  logic [VALUE_WIDTH-1:0] adv;
  value_t                 nv;
  value_t                 nv_lo;
  value_t                 cur_new;

  slsa_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  slsa_alarm u_alarm (
    .value (cur_new),
    .regs  (regs),
    .alarm (alarm)
  );

  assign move_a     = valid_a && (!valid_b || result.ready);
  assign item.ready = !valid_a || move_a;

  always_comb begin
    limits_ok = regs.limit_low < regs.limit_high;
    fresh     = (pv_a != target) && (pv_a != current);
    pv_lo     = (pv_a < regs.limit_low) ? regs.limit_low : pv_a;
    pv_clamp  = (pv_lo > regs.limit_high) ? regs.limit_high : pv_lo;
    tgt_sel   = fresh ? pv_clamp : target;

    // distance as an unsigned magnitude, one bit wider to avoid overflow
    diff     = {tgt_sel[VALUE_WIDTH-1], tgt_sel} - {current[VALUE_WIDTH-1], current};
    diff_neg = -diff;
    up       = !diff[VALUE_WIDTH];
    gap      = up ? diff[VALUE_WIDTH-1:0] : diff_neg[VALUE_WIDTH-1:0];
    step_ext = {1'b0, regs.max_step};
    adv      = (gap < step_ext) ? gap : step_ext;
    nv       = up ? value_t'(current + adv) : value_t'(current - adv);
    nv_lo    = (nv < regs.limit_low) ? regs.limit_low : nv;
    cur_new  = (tgt_sel != current) ?
               ((nv_lo > regs.limit_high) ? regs.limit_high : nv_lo) : current;

    target_next  = target;
    current_next = current;
    sev_next     = kept_sev;
    kind_next    = kept_kind;
    vout_next    = pv_a;
    status_next  = ST_FULL;

    if (!limits_ok) begin
      status_next = ST_LIMITS_BAD;
    end else if (!fresh && (target == current)) begin
      status_next = ST_AT_TARGET;
    end else begin
      target_next  = tgt_sel;
      current_next = cur_new;
      vout_next    = cur_new;
      if (!alarm.ok) begin
        status_next = ST_ALARM_BAD;
      end else if (alarm.sev != kept_sev) begin
        sev_next  = alarm.sev;
        kind_next = alarm.kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      target    <= RST_SETPOINT;
      current   <= RST_SETPOINT;
      kept_sev  <= SEV_NONE;
      kept_kind <= KIND_NONE;
    end else begin
      if (item.valid && item.ready) begin
        valid_a <= 1'b1;
      end else if (move_a) begin
        valid_a <= 1'b0;
      end
      if (move_a) begin
        valid_b   <= 1'b1;
        target    <= target_next;
        current   <= current_next;
        kept_sev  <= sev_next;
        kept_kind <= kind_next;
      end else if (result.ready) begin
        valid_b <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      pv_a <= item.presented_value;
    end
    if (move_a) begin
      vout       <= vout_next;
      sev_out    <= sev_next;
      kind_out   <= kind_next;
      status_out <= status_next;
    end
  end

  assign result.valid       = valid_b;
  assign result.value_out   = vout;
  assign result.severity    = sev_out;
  assign result.alarm_kind  = kind_out;
  assign result.pass_status = status_out;

`ifndef SYNTH
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    (move_a && (status_next == ST_LIMITS_BAD || status_next == ST_AT_TARGET)) |=>
    (target == $past(target) && current == $past(current) && kept_sev == $past(kept_sev)))
    else $error("state changed on a pass that must leave it alone");

  a_kind_matches_sev: assert property (@(posedge clk) disable iff (rst)
    (kept_sev == SEV_NONE && kept_kind == KIND_NONE) ||
    (kept_sev == SEV_MINOR && (kept_kind == KIND_MINOR_LOW || kept_kind == KIND_MINOR_HIGH)) ||
    (kept_sev == SEV_MAJOR && (kept_kind == KIND_MAJOR_LOW || kept_kind == KIND_MAJOR_HIGH)))
    else $error("kept alarm kind disagrees with kept severity");

  a_word_reaches_output: assert property (@(posedge clk) disable iff (rst)
    move_a |=> (valid_b && status_out == $past(status_next)))
    else $error("processed word did not reach the output register");
`endif

endmodule

`default_nettype wire
